/* rtl/sirs_pkg.sv */
// Shared types and constants for the signed integer to radix symbols block.
package sirs_pkg;

	localparam logic [7:0] MINUS_CHAR = 8'h2D;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam int         SYMBOL_BYTES = 32;
	localparam int         SIZE_W = 6;
	localparam int         CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_SIZE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYM0      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYM1      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SYM2      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SYM3      = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} back_state_t;

	typedef enum logic [1:0] {
		VS_IDLE,
		VS_SCAN,
		VS_DONE
	} vchk_state_t;

endpackage

/* rtl/sirs_front.sv */
// Front: accepts numbers, splits sign and magnitude, queues them for the back.
module sirs_front #(
	parameter int VALUE_WIDTH = 32,
	parameter int DEPTH_LOG = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [VALUE_WIDTH-1:0] in_number,
	input  logic                   enable,
	output logic                   q_valid,
	input  logic                   q_ready,
	output logic                   q_neg,
	output logic [VALUE_WIDTH-1:0] q_mag
);
	localparam int DEPTH = 1 << DEPTH_LOG;

	logic [VALUE_WIDTH-1:0] mag_q [DEPTH];
	logic                   neg_q [DEPTH];
	logic [DEPTH_LOG-1:0]   wr_q, rd_q;
	logic [DEPTH_LOG:0]     cnt_q;
	logic                   push, pop;

	assign in_ready = (cnt_q != (DEPTH_LOG + 1)'(DEPTH));
	// invalid base: the item is consumed but never queued
	assign push = in_valid && in_ready && enable;
	assign pop  = q_valid && q_ready;
	assign q_valid = (cnt_q != '0);
	assign q_neg = neg_q[rd_q];
	assign q_mag = mag_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			neg_q[wr_q] <= in_number[VALUE_WIDTH-1];
			mag_q[wr_q] <= in_number[VALUE_WIDTH-1] ? (~in_number + 1'b1) : in_number;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {{DEPTH_LOG{1'b0}}, push} - {{DEPTH_LOG{1'b0}}, pop};
		end
	end
endmodule

/* rtl/sirs_back.sv */
// Back: iterative restoring division by the radix, digit stack, symbol output.
module sirs_back #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_ready,
	input  logic                   q_neg,
	input  logic [VALUE_WIDTH-1:0] q_mag,
	input  logic [sirs_pkg::SIZE_W-1:0] radix,
	input  logic [255:0]           symbols,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_symbol,
	output logic                   out_last
);
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int DIG_W = $clog2(VALUE_WIDTH + 2);
	localparam int IDX_W = $clog2(VALUE_WIDTH);

	sirs_pkg::back_state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0]      quo_q;
	logic [sirs_pkg::SIZE_W-1:0] rem_q;
	logic [CNT_W-1:0]            bit_q;
	logic [4:0]                  digits_q [VALUE_WIDTH];
	logic [DIG_W-1:0]            nd_q;
	logic                        neg_q;

	logic [sirs_pkg::SIZE_W:0]   trial;
	logic                        ge;
	logic [sirs_pkg::SIZE_W-1:0] rem_n;
	logic                        pop;
	logic                        last_bit;
	logic [4:0]                  dsel;

	assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign ge = trial >= {1'b0, radix};
	assign rem_n = ge ? sirs_pkg::SIZE_W'(trial - {1'b0, radix}) : trial[sirs_pkg::SIZE_W-1:0];
	assign last_bit = (bit_q == CNT_W'(VALUE_WIDTH - 1));

	assign q_ready = (state_q == sirs_pkg::ST_IDLE);
	assign out_valid = (state_q == sirs_pkg::ST_EMIT);
	assign dsel = digits_q[IDX_W'(nd_q - 1'b1)];
	assign out_symbol = neg_q ? sirs_pkg::MINUS_CHAR : symbols[{dsel, 3'b000} +: 8];
	assign out_last = !neg_q && (nd_q == DIG_W'(1));
	assign pop = out_valid && out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sirs_pkg::ST_IDLE: if (q_valid) state_d = sirs_pkg::ST_DIV;
			sirs_pkg::ST_DIV:  if (last_bit && {quo_q[VALUE_WIDTH-2:0], ge} == '0)
				state_d = sirs_pkg::ST_EMIT;
			sirs_pkg::ST_EMIT: if (pop && out_last) state_d = sirs_pkg::ST_IDLE;
			default: state_d = sirs_pkg::ST_IDLE;
		endcase
	end

	// each DIV pass shifts VALUE_WIDTH bits; quotient builds in quo_q's low end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sirs_pkg::ST_IDLE;
			nd_q <= '0;
			neg_q <= 1'b0;
			bit_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				sirs_pkg::ST_IDLE: if (q_valid) begin
					neg_q <= q_neg;
					nd_q <= '0;
					bit_q <= '0;
				end
				sirs_pkg::ST_DIV: begin
					if (last_bit) begin
						bit_q <= '0;
						nd_q <= nd_q + 1'b1;
					end else begin
						bit_q <= bit_q + 1'b1;
					end
				end
				sirs_pkg::ST_EMIT: if (pop) begin
					if (neg_q) neg_q <= 1'b0;
					else if (!out_last) nd_q <= nd_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == sirs_pkg::ST_IDLE) begin
			quo_q <= q_mag;
			rem_q <= '0;
		end else if (state_q == sirs_pkg::ST_DIV) begin
			quo_q <= {quo_q[VALUE_WIDTH-2:0], ge};
			if (last_bit) begin
				digits_q[nd_q[IDX_W-1:0]] <= rem_n[4:0];
				rem_q <= '0;
			end else begin
				rem_q <= rem_n;
			end
		end
	end
endmodule

/* rtl/signed_integer_to_radix_symbols.sv */
// Top level: signed value to text in a configurable radix.
//
// channel | dir | handshake              | payload
// s_axis  | in  | s_axis_tvalid/tready   | number (tdata)
// m_axis  | out | m_axis_tvalid/tready   | symbol (tdata), last (tlast)
// cfg     | in  | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// A number leaves the queue, then the bit-serial radix divider works out its
// digits one by one, then the symbols go out while the receiver is ready.
// Any configuration write starts a validity scan during which no item is
// accepted. Reset leaves base_size 0: items are swallowed silently until a
// valid base is configured. A two-entry queue parts the front from the
// divider, so input stalls only when it is full or a scan is running.
module signed_integer_to_radix_symbols #(
	parameter int MAX_SYMBOLS = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [VALUE_WIDTH-1:0] s_axis_tdata, // [VW-1:0] number
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,  // [7:0] symbol
	output logic                 m_axis_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [sirs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data
);
	logic [sirs_pkg::SIZE_W-1:0] size_q;
	logic [255:0]                sym_q;
	logic                        valid_q;
	logic                        scan_q;
	logic [4:0]                  i_q;
	logic                        bad_q;
	logic                        f_ready, q_valid, q_ready, q_neg;
	logic [VALUE_WIDTH-1:0]      q_mag;
	logic [7:0]                  c;
	logic                        hit;

	assign cfg_ready = 1'b1;

	// Validity scan: one symbol a cycle, compared against all other used ones.
	assign c = sym_q[{i_q, 3'b000} +: 8];
	always_comb begin
		hit = 1'b0;
		for (int j = 0; j < 32; j++)
			if (j < int'(size_q) && j != int'(i_q) && sym_q[8*j +: 8] == c) hit = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			sym_q <= '0;
			valid_q <= 1'b0;
			scan_q <= 1'b0;
			i_q <= '0;
			bad_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sirs_pkg::REG_BASE_SIZE: size_q <= cfg_data[sirs_pkg::SIZE_W-1:0];
				sirs_pkg::REG_SYM0: sym_q[63:0] <= cfg_data;
				sirs_pkg::REG_SYM1: sym_q[127:64] <= cfg_data;
				sirs_pkg::REG_SYM2: sym_q[191:128] <= cfg_data;
				sirs_pkg::REG_SYM3: sym_q[255:192] <= cfg_data;
				default: ;
			endcase
			valid_q <= 1'b0;
			scan_q <= 1'b1;
			i_q <= '0;
			bad_q <= 1'b0;
		end else if (scan_q) begin
			if (int'(i_q) < int'(size_q) &&
				(c == 8'h00 || c == sirs_pkg::MINUS_CHAR || c == sirs_pkg::PLUS_CHAR || hit))
				bad_q <= 1'b1;
			i_q <= i_q + 1'b1;
			if (i_q == 5'd31) begin
				scan_q <= 1'b0;
				valid_q <= !bad_q && !(int'(i_q) < int'(size_q) &&
					(c == 8'h00 || c == sirs_pkg::MINUS_CHAR || c == sirs_pkg::PLUS_CHAR || hit))
					&& size_q >= 6'd2 && int'(size_q) <= MAX_SYMBOLS;
			end
		end
	end

	// While scanning, hold input; with invalid base, accept and discard.
	assign s_axis_tready = !scan_q && (f_ready || !valid_q);

	sirs_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid && !scan_q), .in_ready(f_ready),
		.in_number(s_axis_tdata), .enable(valid_q),
		.q_valid, .q_ready, .q_neg, .q_mag
	);

	sirs_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_neg, .q_mag,
		.radix(size_q), .symbols(sym_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_symbol(m_axis_tdata), .out_last(m_axis_tlast)
	);
endmodule

/* rtl/sirs_checker.sv */
// Port-level checks for the radix symbol converter, bound to the top level.
module sirs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata == sirs_pkg::MINUS_CHAR |-> !m_axis_tlast)
		else $error("minus sign ended a run");
	a_no_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata != 8'h00)
		else $error("zero symbol emitted");
endmodule

bind signed_integer_to_radix_symbols sirs_checker u_chk (
	.clk, .arst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

/* tb/signed_integer_to_radix_symbols_tb.sv */
// Testbench for signed_integer_to_radix_symbols: number-to-text checks across several bases.
module signed_integer_to_radix_symbols_tb;

	localparam int N_RANDOM  = 88;
	localparam int CYC_LIMIT = 900000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [sirs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;

	// Expected output character: symbol byte plus end-of-run flag.
	typedef struct packed {
		logic [7:0] sym;
		logic       lst;
	} char_t;

	// Directed row: value, and a hand-typed first character when obvious.
	typedef struct {
		logic [31:0] val;
		logic        has_first;
		logic [7:0]  first_sym;
	} drow_t;

	char_t       pending_chars[$];
	logic [5:0]  radix_q;
	logic [63:0] sym_word_q[4];
	int          mismatches;
	int          chars_seen;
	int          items_sent;
	int          cycles = 0;
	bit          drain_phase;     // no idling near the end
	bit          hold_rx;         // long receiver hold-off

	signed_integer_to_radix_symbols i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),   // [31:0] number
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),   // [7:0] symbol
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Timeout guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [7:0] digit_sym(input int idx);
		return sym_word_q[idx / 8][(idx % 8) * 8 +: 8];
	endfunction

	function automatic bit radix_ok();
		int n;
		logic [7:0] c;
		n = radix_q;
		if (n < 2 || n > 32)
			return 0;
		for (int i = 0; i < n; i++) begin
			c = digit_sym(i);
			if (c == 8'h00 || c == sirs_pkg::MINUS_CHAR || c == sirs_pkg::PLUS_CHAR)
				return 0;
			for (int j = i + 1; j < n; j++)
				if (digit_sym(j) == c)
					return 0;
		end
		return 1;
	endfunction

	// Queue up the expected text of one number.
	task automatic predict_text(input logic [31:0] val);
		logic [31:0] mag;
		logic [7:0]  digs[$];
		if (!radix_ok())
			return;
		mag = val[31] ? (~val + 32'd1) : val;
		do begin
			digs.push_front(digit_sym(mag % radix_q));
			mag = mag / radix_q;
		end while (mag != 0);
		if (val[31])
			pending_chars.push_back('{sirs_pkg::MINUS_CHAR, 1'b0});
		foreach (digs[k])
			pending_chars.push_back('{digs[k], k == digs.size() - 1});
	endtask

	// Output checker: compares every accepted character with the oldest expectation.
	always @(posedge clk) begin
		char_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			chars_seen++;
			if (pending_chars.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected char %h last %b", m_axis_tdata, m_axis_tlast);
			end else begin
				want = pending_chars.pop_front();
				if (want.sym !== m_axis_tdata || want.lst !== m_axis_tlast) begin
					mismatches++;
					if (mismatches <= 10)
						$display("char mismatch: exp %h/%b got %h/%b", want.sym, want.lst,
							m_axis_tdata, m_axis_tlast);
				end
			end
		end
	end

	// Receiver: random stall bursts, one long hold-off on request.
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				m_axis_tready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_rx = 0;
			end
			if (!drain_phase && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 5);
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// One register write; the channel then idles before the task returns.
	task automatic write_reg(input logic [sirs_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == sirs_pkg::REG_BASE_SIZE)
			radix_q = val[5:0];
		else if (idx <= sirs_pkg::REG_SYM3)
			sym_word_q[idx - 1] = val;
		@(posedge clk);
	endtask

	// Offers one number; valid stays up until the next item or an idle stretch.
	task automatic send_number(input logic [31:0] val);
		if (!drain_phase && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= val;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_text(val);
		items_sent++;
	endtask

	// Wait until nothing is expected, then the worst per-number latency.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	// Load a full symbol set; digits 0-9, then letters; then set the base size.
	task automatic load_symbols(input logic [5:0] radix);
		logic [7:0] set[32];
		for (int i = 0; i < 32; i++)
			set[i] = (i < 10) ? 8'(8'h30 + i) : 8'(8'h41 + (i - 10));
		for (int w = 0; w < 4; w++)
			write_reg(sirs_pkg::CFG_IDX_W'(sirs_pkg::REG_SYM0 + w),
				{set[w*8+7], set[w*8+6], set[w*8+5], set[w*8+4],
				set[w*8+3], set[w*8+2], set[w*8+1], set[w*8]});
		write_reg(sirs_pkg::REG_BASE_SIZE, {58'd0, radix});
	endtask

	initial begin
		drow_t dir[$];
		logic [31:0] v;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		radix_q = '0;
		foreach (sym_word_q[i]) sym_word_q[i] = '0;
		mismatches = 0;
		chars_seen = 0;
		items_sent = 0;
		drain_phase = 0;
		hold_rx = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Silent after reset: base_size is 0.
		send_number(32'd5);
		send_number(32'h8000_0000);
		settle();

		// Decimal base, directed extremes.
		load_symbols(6'd10);
		dir = '{
			'{32'd0,          1, 8'h30},
			'{32'h8000_0000,  1, sirs_pkg::MINUS_CHAR},
			'{32'h7FFF_FFFF,  1, 8'h32},
			'{32'hFFFF_FFFF,  1, sirs_pkg::MINUS_CHAR},
			'{32'd9,          1, 8'h39},
			'{32'd10,         1, 8'h31},
			'{32'h5555_5555,  0, 8'h00},
			'{32'hAAAA_AAAA,  0, 8'h00}
		};
		foreach (dir[r]) begin
			send_number(dir[r].val);
			if (dir[r].has_first) begin
				// nothing else is pending here, so the head is this number's first char
				if (pending_chars.size() == 0 || pending_chars[0].sym !== dir[r].first_sym) begin
					mismatches++;
					if (mismatches <= 10)
						$display("first char of %h: exp %h", dir[r].val, dir[r].first_sym);
				end
				settle();
			end
		end
		settle();

		// Binary (longest output, 33 chars for the most negative value).
		load_symbols(6'd2);
		send_number(32'h8000_0000);
		send_number(32'h7FFF_FFFF);
		send_number(32'd0);
		settle();

		// Radix 32, plus invalid bases: minus, zero byte, repeated symbol, plus, size 1, 33 and 63.
		load_symbols(6'd32);
		send_number(32'h8000_0000);
		send_number(32'd31);
		settle();
		write_reg(sirs_pkg::REG_SYM0, (64'h3736353433323130 & ~64'hFF) | 64'h2D); // '-' used
		send_number(32'd77);
		settle();
		write_reg(sirs_pkg::REG_SYM0, 64'h3736353433323130 & ~64'hFF);  // zero byte
		send_number(32'd77);
		settle();
		write_reg(sirs_pkg::REG_SYM0, 64'h3736353433323131);            // repeat
		send_number(32'd77);
		settle();
		write_reg(sirs_pkg::REG_SYM0, 64'h373635343332312B);            // '+'
		send_number(32'd77);
		settle();
		write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);             // ignored index
		load_symbols(6'd1);
		send_number(32'd3);
		settle();
		write_reg(sirs_pkg::REG_BASE_SIZE, 64'd33);
		send_number(32'd3);
		settle();
		write_reg(sirs_pkg::REG_BASE_SIZE, 64'd63);
		send_number(32'd3);
		settle();

		// Base 16, then random bases, with random values and one long receiver hold-off.
		for (int ph = 0; ph < 4; ph++) begin
			load_symbols(ph == 0 ? 6'd16 : 6'($urandom_range(2, 32)));
			if (ph == 1)
				hold_rx = 1;
			if (ph == 3)
				drain_phase = 1;
			for (int i = 0; i < N_RANDOM / 4; i++) begin
				case ($urandom_range(0, 3))
					0: v = $urandom_range(0, 40);
					1: v = -$urandom_range(0, 40);
					default: v = $urandom;
				endcase
				send_number(v);
			end
			settle();
		end

		$display("run covered %0d numbers and %0d output chars over radix 2..32,",
			items_sent, chars_seen);
		$display("invalid bases and back-pressure; %0d mismatches", mismatches);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
